// ===== design/rrla_pkg.sv =====
// ----------------------------------------------------------------------------
// rrla_pkg
// Shared types and constants for the round-robin lease allocator.
// ----------------------------------------------------------------------------
package rrla_pkg;

	localparam int MAX_PORTS_DEF = 64;

	// register reset values
	localparam logic [15:0] RST_RANGE_START = 16'd54300;
	localparam logic [15:0] RST_RANGE_END   = 16'd54320;
	localparam logic [31:0] RST_LEASE_LIMIT = 32'd120;

	// register indexes
	localparam logic [1:0] REG_RANGE_START = 2'd0;
	localparam logic [1:0] REG_RANGE_END   = 2'd1;
	localparam logic [1:0] REG_LEASE_LIMIT = 2'd2;

	// request modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ALLOC  = 2'd1;
	localparam logic [1:0] MODE_EXTEND = 2'd2;
	localparam logic [1:0] MODE_VIEW   = 2'd3;

	// result status
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NONE_FREE  = 2'd1;
	localparam logic [1:0] ST_NOT_LEASED = 2'd2;

	typedef struct packed {
		logic        used;
		logic [30:0] owner;
		logic [31:0] stamp;
	} entry_t;

endpackage

// ===== design/round_robin_lease_allocator.sv =====
// ----------------------------------------------------------------------------
// round_robin_lease_allocator
// Leases port numbers from a configured range with a rotating search pointer.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its result has been
// loaded into the output register. A tick advances the seconds count and goes
// straight to the result. Extend and view pass through range setup, lookup
// read, evaluate and result. An allocate examines entries from the pointer
// until a claimable one is found, or all n ports of the range when all are
// busy: the entry table is one RAM with a single read port, read once per
// cycle in a pipelined scan, and the one age comparator checks one entry per
// cycle. After reset a clearing pass wipes the table; no item is accepted
// during it, configuration writes are taken as usual.
// ----------------------------------------------------------------------------
module round_robin_lease_allocator
	import rrla_pkg::*;
#(
	parameter int MAX_PORTS = MAX_PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] port,
	input  logic [30:0] owner_id,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] port_number,
	output logic        in_use,
	output logic        expired,
	output logic [30:0] owner_out,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_PORTS);
	localparam int CW = $clog2(MAX_PORTS + 1);
	localparam int EW = $bits(entry_t);

	// sequencer states
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_ALLOC  = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_LOOKUP = 3'd5;
	localparam logic [2:0] S_RDWAIT = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]    state_q;

	// configuration registers
	logic [15:0]   range_start_q;
	logic [15:0]   range_end_q;
	logic [31:0]   lease_limit_q;

	logic [15:0]   next_ptr_q;
	logic [31:0]   seconds_q;
	logic [AW-1:0] clr_q;

	// latched request
	logic [1:0]    req_mode_q;
	logic [15:0]   req_port_q;
	logic [30:0]   req_owner_q;

	// effective range
	logic [15:0]   last_q;
	logic          empty_q;

	// scan walker and read pipeline
	logic [15:0]   scan_port_q;
	logic [AW-1:0] scan_off_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic          rd_valid_s1;
	logic [15:0]   rd_port_s1;
	logic [AW-1:0] rd_off_s1;
	logic [AW-1:0] slot_q;

	// pending result
	logic [1:0]    res_status_q;
	logic [15:0]   res_port_q;
	logic          res_used_q;
	logic          res_exp_q;
	logic [30:0]   res_owner_q;

	// output register
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [15:0]   out_port_q;
	logic          out_used_q;
	logic          out_exp_q;
	logic [30:0]   out_owner_q;

	// RAM ports
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_word;
	entry_t        rd_entry;

	logic          age_exp;
	logic          age_free;

	// combinational helpers
	logic [16:0]   cap_wide;
	logic [15:0]   cap;
	logic [15:0]   last_c;
	logic          ptr_ok;
	logic [15:0]   ptr0;
	logic [15:0]   span;
	logic          port_inside;
	logic [15:0]   port_off;
	logic [15:0]   scan_rel;
	logic          out_free;
	logic          scan_issue;
	logic          scan_wrap;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign rd_entry = entry_t'(rd_word);

	// last port: range_end capped at range_start + MAX_PORTS - 1 and 65535
	assign cap_wide = {1'b0, range_start_q} + 17'(MAX_PORTS - 1);
	assign cap      = cap_wide[16] ? 16'hFFFF : cap_wide[15:0];
	assign last_c   = (range_end_q > cap) ? cap : range_end_q;

	// out-of-range pointer restarts at the first port
	assign ptr_ok   = (next_ptr_q >= range_start_q) && (next_ptr_q <= last_q);
	assign ptr0     = ptr_ok ? next_ptr_q : range_start_q;
	assign span     = last_q - range_start_q;
	assign scan_rel = ptr0 - range_start_q;

	assign port_inside = !empty_q && (req_port_q >= range_start_q) && (req_port_q <= last_q);
	assign port_off    = req_port_q - range_start_q;

	assign scan_issue = (cnt_q < n_q);
	assign scan_wrap  = (scan_port_q >= last_q);

	rrla_age_unit u_age (
		.now     (seconds_q),
		.entry   (rd_entry),
		.limit   (lease_limit_q),
		.expired (age_exp),
		.free    (age_free)
	);

	rrla_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_PORTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// table access
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = clr_q;
		wr_entry = '0;
		rd_en    = 1'b0;
		rd_addr  = scan_off_q;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				rd_en = scan_issue;
				if (rd_valid_s1 && age_free) begin
					wr_en    = 1'b1;
					wr_addr  = rd_off_s1;
					wr_entry = '{used: 1'b1, owner: req_owner_q, stamp: seconds_q};
				end
			end
			S_LOOKUP: begin
				rd_en   = port_inside;
				rd_addr = port_off[AW-1:0];
			end
			S_RDWAIT: begin
				if (req_mode_q == MODE_EXTEND && rd_entry.used) begin
					wr_en    = 1'b1;
					wr_addr  = slot_q;
					wr_entry = '{used: 1'b1, owner: req_owner_q, stamp: seconds_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			range_start_q <= RST_RANGE_START;
			range_end_q   <= RST_RANGE_END;
			lease_limit_q <= RST_LEASE_LIMIT;
			next_ptr_q    <= RST_RANGE_START;
			seconds_q     <= '0;
			clr_q         <= '0;
			rd_valid_s1   <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_START: range_start_q <= cfg_data[15:0];
					REG_RANGE_END:   range_end_q   <= cfg_data[15:0];
					REG_LEASE_LIMIT: lease_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			rd_valid_s1 <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_PORTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_mode_q   <= mode;
						req_port_q   <= port;
						req_owner_q  <= owner_id;
						res_status_q <= ST_OK;
						res_port_q   <= '0;
						res_used_q   <= 1'b0;
						res_exp_q    <= 1'b0;
						res_owner_q  <= '0;
						if (mode == MODE_TICK) begin
							seconds_q <= seconds_q + 32'd1;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					last_q  <= last_c;
					empty_q <= last_c < range_start_q;
					state_q <= (req_mode_q == MODE_ALLOC) ? S_ALLOC : S_LOOKUP;
				end
				S_ALLOC: begin
					if (empty_q) begin
						res_status_q <= ST_NONE_FREE;
						state_q      <= S_DONE;
					end else begin
						next_ptr_q  <= ptr0;
						scan_port_q <= ptr0;
						scan_off_q  <= scan_rel[AW-1:0];
						cnt_q       <= '0;
						n_q         <= span[CW-1:0] + 1'b1;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						rd_valid_s1 <= 1'b1;
						rd_port_s1  <= scan_port_q;
						rd_off_s1   <= scan_off_q;
						cnt_q       <= cnt_q + 1'b1;
						scan_port_q <= scan_wrap ? range_start_q : scan_port_q + 16'd1;
						scan_off_q  <= scan_wrap ? '0 : scan_off_q + 1'b1;
					end
					if (rd_valid_s1 && age_free) begin
						// claimed; pointer moves past it, wrapping at 65535
						next_ptr_q   <= rd_port_s1 + 16'd1;
						res_port_q   <= rd_port_s1;
						rd_valid_s1  <= 1'b0;
						state_q      <= S_DONE;
					end else if (!rd_valid_s1 && !scan_issue) begin
						// full pass, nothing free
						res_status_q <= ST_NONE_FREE;
						state_q      <= S_DONE;
					end
				end
				S_LOOKUP: begin
					res_port_q <= req_port_q;
					slot_q     <= port_off[AW-1:0];
					if (port_inside) begin
						state_q <= S_RDWAIT;
					end else begin
						res_status_q <= ST_NOT_LEASED;
						state_q      <= S_DONE;
					end
				end
				S_RDWAIT: begin
					if (!rd_entry.used) begin
						res_status_q <= ST_NOT_LEASED;
					end else if (req_mode_q == MODE_VIEW) begin
						res_used_q  <= 1'b1;
						res_exp_q   <= age_exp;
						res_owner_q <= rd_entry.owner;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_port_q   <= res_port_q;
						out_used_q   <= res_used_q;
						out_exp_q    <= res_exp_q;
						out_owner_q  <= res_owner_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign port_number = out_port_q;
	assign in_use      = out_used_q;
	assign expired     = out_exp_q;
	assign owner_out   = out_owner_q;

endmodule

// ===== design/rrla_ram.sv =====
// ----------------------------------------------------------------------------
// rrla_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rrla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/rrla_age_unit.sv =====
// ----------------------------------------------------------------------------
// rrla_age_unit
// Lease age check: (now - stamp) mod 2^32 compared against the limit.
// ----------------------------------------------------------------------------
module rrla_age_unit
	import rrla_pkg::*;
(
	input  logic [31:0] now,
	input  entry_t      entry,
	input  logic [31:0] limit,
	output logic        expired,
	output logic        free
);

	logic [31:0] age;

	assign age     = now - entry.stamp;
	assign expired = age > limit;
	// claimable by an allocate
	assign free    = !entry.used || expired;

endmodule
